### hw/rtl/date_record_sorter_macros.svh
// Assertion macros shared by the date record sorter checkers.
`ifndef DATE_RECORD_SORTER_MACROS_SVH
`define DATE_RECORD_SORTER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, quiet while reset is low.
`define DRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet while reset is low.
`define DRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/drs_pkg.sv
// Types and constants of the date record sorter.
package drs_pkg;

    localparam int KEY_W   = 22;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int PLATE_W = 64;
    localparam int STAT_W  = 2;

    localparam logic [KEY_W-1:0] DAYS_PER_MONTH = KEY_W'(30);
    localparam logic [KEY_W-1:0] DAYS_PER_YEAR  = KEY_W'(365);

    localparam logic [MONTH_W-1:0] MONTH_MIN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_MAX = MONTH_W'(12);
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_DATE = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNUSED   = 2'd3;

    typedef struct packed {
        logic [DAY_W-1:0]   rec_day;
        logic [MONTH_W-1:0] rec_month;
        logic [YEAR_W-1:0]  rec_year;
        logic [PLATE_W-1:0] plate;
        logic               last_record;
    } t_in;

    typedef struct packed {
        logic [DAY_W-1:0]   out_day;
        logic [MONTH_W-1:0] out_month;
        logic [YEAR_W-1:0]  out_year;
        logic [PLATE_W-1:0] out_plate;
        logic [STAT_W-1:0]  status;
        logic               last_result;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [PLATE_W-1:0] plate;
    } t_entry;

endpackage

### hw/rtl/date_record_sorter.sv
// Date record sorter: loads dated records and emits them in descending date order.
//
// Records are loaded one item per cycle while busy is low; each is checked, given
// the key day + month*30 + year*365 and written in load order into a single-port
// record memory. The item carrying last_record ends the set. If any date in the
// set was out of range, or nothing was stored, one result comes out on the next
// cycle with zero payload and last_result set. Otherwise busy rises and the block
// emits the n stored records in descending key order; equal keys leave in load
// order. For each result the memory's one read port is swept over all n entries
// to pick the largest key not yet sent. Results are strobed for a single cycle
// on o_strobe and cannot be held off. Records past MAX_RECORDS are dropped and
// every result of that run carries the overflow status; a bad date overrides
// overflow. After the final result the block is empty, and busy falls in the
// cycle that shows that result.
module date_record_sorter #(
    parameter int MAX_RECORDS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  drs_pkg::t_in  i_item,
    output logic          o_strobe,
    output drs_pkg::t_out o_result
);
    import drs_pkg::*;

    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_RECORDS);

    localparam logic S_LOAD = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // Record memory, written in load order, read one entry per cycle while a sweep issues reads.
    t_entry mem [MAX_RECORDS];

    logic                   r_state;
    logic [CW-1:0]          r_count;
    logic                   r_bad;
    logic                   r_ovf;
    logic [STAT_W-1:0]      r_status;
    logic [MAX_RECORDS-1:0] r_done;
    logic [CW-1:0]          r_ra_cnt;
    logic [CW-1:0]          r_emit_cnt;
    logic                   r_rv;
    logic [AW-1:0]          r_rtag;
    t_entry                 r_rdata;
    logic                   r_have;
    t_entry                 r_best;
    logic [AW-1:0]          r_best_idx;
    logic                   r_out_stb;
    t_out                   r_out;

    logic              accept;
    logic              date_ok;
    logic              room;
    logic              store;
    logic              set_end_short;
    logic [KEY_W-1:0]  n_key;
    t_entry            n_entry;
    logic [CW-1:0]     n_count;
    logic              n_bad;
    logic              n_ovf;
    logic [STAT_W-1:0] n_short_status;
    logic              issue;
    logic              cand;
    logic              finish;
    logic              emit_last;

    assign busy     = (r_state != S_LOAD);
    assign o_strobe = r_out_stb;
    assign o_result = r_out;

    // Load side: check the date, form the key, append while room remains.
    always_comb begin
        accept  = start && !busy;
        date_ok = (i_item.rec_day != '0) &&
                  (i_item.rec_month inside {[MONTH_MIN:MONTH_MAX]}) &&
                  (i_item.rec_year <= YEAR_MAX);
        room    = (r_count < FULL);
        store   = accept && date_ok && room;
        n_key   = KEY_W'(i_item.rec_day)
                + KEY_W'(i_item.rec_month) * DAYS_PER_MONTH
                + KEY_W'(i_item.rec_year) * DAYS_PER_YEAR;
        n_entry.key   = n_key;
        n_entry.day   = i_item.rec_day;
        n_entry.month = i_item.rec_month;
        n_entry.year  = i_item.rec_year;
        n_entry.plate = i_item.plate;
        n_count = r_count + CW'(store);
        n_bad   = r_bad || (accept && !date_ok);
        n_ovf   = r_ovf || (accept && date_ok && !room);
        // A set that ends bad or empty answers with a single result at once.
        set_end_short  = accept && i_item.last_record && (n_bad || (n_count == '0));
        n_short_status = n_bad ? ST_BAD_DATE : (n_ovf ? ST_OVERFLOW : ST_OK);
    end

    // Output side: sweep the memory, keep the first largest key not yet sent.
    always_comb begin
        issue     = (r_state == S_SCAN) && (r_ra_cnt != r_count);
        cand      = r_rv && !r_done[r_rtag] && (!r_have || (r_rdata.key > r_best.key));
        finish    = (r_state == S_SCAN) && (r_ra_cnt == r_count) && !r_rv;
        emit_last = (CW'(r_emit_cnt + CW'(1)) == r_count);
    end

    // Memory port: one write on load, one registered read on the sweep.
    always_ff @(posedge i_clk) begin
        if (store) begin
            mem[r_count[AW-1:0]] <= n_entry;
        end
        if (issue) begin
            r_rdata <= mem[r_ra_cnt[AW-1:0]];
        end
    end

    // Sweep payload: tag of the read in flight and the best entry so far.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rtag <= r_ra_cnt[AW-1:0];
        end
        if (cand) begin
            r_best     <= r_rdata;
            r_best_idx <= r_rtag;
        end
    end

    // Result register: short answer at set end, or the winner of a sweep.
    always_ff @(posedge i_clk) begin
        if (set_end_short) begin
            r_out.out_day     <= '0;
            r_out.out_month   <= '0;
            r_out.out_year    <= '0;
            r_out.out_plate   <= '0;
            r_out.status      <= n_short_status;
            r_out.last_result <= 1'b1;
        end else if (finish) begin
            r_out.out_day     <= r_best.day;
            r_out.out_month   <= r_best.month;
            r_out.out_year    <= r_best.year;
            r_out.out_plate   <= r_best.plate;
            r_out.status      <= r_status;
            r_out.last_result <= emit_last;
        end
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_count    <= '0;
            r_bad      <= 1'b0;
            r_ovf      <= 1'b0;
            r_status   <= ST_OK;
            r_done     <= '0;
            r_ra_cnt   <= '0;
            r_emit_cnt <= '0;
            r_rv       <= 1'b0;
            r_have     <= 1'b0;
            r_out_stb  <= 1'b0;
        end else begin
            r_out_stb <= set_end_short || finish;
            case (r_state)
                S_LOAD: begin
                    if (set_end_short) begin
                        // Drop the set and report it in one item.
                        r_count <= '0;
                        r_bad   <= 1'b0;
                        r_ovf   <= 1'b0;
                    end else if (accept) begin
                        r_count <= n_count;
                        r_bad   <= n_bad;
                        r_ovf   <= n_ovf;
                        if (i_item.last_record) begin
                            r_state    <= S_SCAN;
                            r_status   <= n_ovf ? ST_OVERFLOW : ST_OK;
                            r_ra_cnt   <= '0;
                            r_emit_cnt <= '0;
                            r_rv       <= 1'b0;
                            r_have     <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    r_rv <= issue;
                    if (issue) begin
                        r_ra_cnt <= r_ra_cnt + CW'(1);
                    end
                    if (cand) begin
                        r_have <= 1'b1;
                    end
                    if (finish) begin
                        // Send the winner, mark it, restart the sweep.
                        r_emit_cnt <= r_emit_cnt + CW'(1);
                        r_ra_cnt   <= '0;
                        r_have     <= 1'b0;
                        if (emit_last) begin
                            r_state <= S_LOAD;
                            r_count <= '0;
                            r_bad   <= 1'b0;
                            r_ovf   <= 1'b0;
                            r_done  <= '0;
                        end else begin
                            r_done[r_best_idx] <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

### hw/rtl/drs_checker.sv
// Port checker for the date record sorter and its bind.
`include "date_record_sorter_macros.svh"

module drs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input drs_pkg::t_in  i_item,
    input logic          o_strobe,
    input drs_pkg::t_out o_result
);
    import drs_pkg::*;

    `DRS_ASSERT_IMP(a_bad_date_alone, o_strobe && (o_result.status == ST_BAD_DATE), o_result.last_result && (o_result.out_plate == '0) && (o_result.out_year == '0), "bad date result not a lone zero item")
    `DRS_ASSERT_IMP(a_status_code, o_strobe, o_result.status != ST_UNUSED, "unused status code")
    `DRS_ASSERT_IMP(a_busy_midrun, o_strobe && !o_result.last_result, busy, "idle while a run is unfinished")
    `DRS_ASSERT_NXT(a_set_end, start && !busy && i_item.last_record, o_strobe || busy, "set end gave neither result nor run")
    `DRS_ASSERT_NXT(a_gap, o_strobe && !o_result.last_result, !o_strobe, "results of a run back to back")

endmodule

bind date_record_sorter drs_checker u_drs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

### tb/tb_date_record_sorter.sv
// Self-checking testbench for the date record sorter: directed, capacity and random record sets.
module tb_date_record_sorter;
    timeunit 1ns;
    timeprecision 1ps;

    import drs_pkg::*;

    // Keep the depth here in step with the instance below.
    localparam int CAPACITY    = 64;
    localparam int ITEM_TARGET = 420;
    // Even a few full runs plus ~420 items sent with random gaps
    // stay far below this limit.
    localparam int CYCLE_LIMIT = 1_000_000;
    // After the last expected result, watch this long for strays.
    localparam int TAIL_CYCLES = 300;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_in   i_item;
    logic  o_strobe;
    t_out  o_result;

    date_record_sorter #(
        .MAX_RECORDS(CAPACITY)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Sorting predictor: a model insertion chain kept in sorted order.
    // Each accepted item updates the chain; an item with last_record set
    // releases the set's expected results into sorted_results.
    // ------------------------------------------------------------------
    t_entry chain_recs[CAPACITY];
    int     chain_count = 0;
    bit     saw_bad_date = 1'b0;
    bit     saw_overflow = 1'b0;
    t_out   sorted_results[$];

    // Run statistics for the summary
    int sent_count    = 0;
    int sets_done     = 0;
    int bad_runs      = 0;
    int overflow_runs = 0;
    int largest_run   = 0;
    int checked_count = 0;
    int fail_count    = 0;

    // ------------------------------------------------------------------
    // Run-length guard
    // ------------------------------------------------------------------
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sorted_results.size());
            $display("tb_date_record_sorter: FAIL");
            $finish;
        end
    end

    // Append one expected result behind the ones already waiting.
    function automatic void queue_expected(input t_out r);
        sorted_results.insert(sorted_results.size(), r);
    endfunction

    task automatic sort_record(input t_in it);
        logic [KEY_W-1:0]  new_key;
        logic [STAT_W-1:0] run_status;
        t_out              res;
        int                pos;
        if (it.rec_day == '0 || it.rec_month < MONTH_MIN || it.rec_month > MONTH_MAX ||
            it.rec_year > YEAR_MAX) begin
            // Out-of-range date: never stored, poisons the whole set.
            saw_bad_date = 1'b1;
        end else if (chain_count >= CAPACITY) begin
            // Chain full: drop the record, flag the set.
            saw_overflow = 1'b1;
        end else begin
            new_key = KEY_W'(it.rec_day) + KEY_W'(it.rec_month) * DAYS_PER_MONTH +
                      KEY_W'(it.rec_year) * DAYS_PER_YEAR;
            // Go past every key that is greater or equal: equal keys keep load order.
            pos = 0;
            while (pos < chain_count && chain_recs[pos].key >= new_key)
                pos++;
            for (int j = chain_count; j > pos; j--)
                chain_recs[j] = chain_recs[j-1];
            chain_recs[pos] = '{key: new_key, day: it.rec_day, month: it.rec_month,
                                year: it.rec_year, plate: it.plate};
            chain_count++;
        end

        if (!it.last_record)
            return;

        sets_done++;
        res = '0;
        res.last_result = 1'b1;
        if (saw_bad_date) begin
            // One zero-payload error result stands in for the run.
            bad_runs++;
            res.status = ST_BAD_DATE;
            queue_expected(res);
        end else begin
            run_status = saw_overflow ? ST_OVERFLOW : ST_OK;
            if (saw_overflow)
                overflow_runs++;
            if (chain_count > largest_run)
                largest_run = chain_count;
            if (chain_count == 0) begin
                res.status = run_status;
                queue_expected(res);
            end
            for (int k = 0; k < chain_count; k++) begin
                res.out_day     = chain_recs[k].day;
                res.out_month   = chain_recs[k].month;
                res.out_year    = chain_recs[k].year;
                res.out_plate   = chain_recs[k].plate;
                res.status      = run_status;
                res.last_result = (k == chain_count - 1);
                queue_expected(res);
            end
        end
        // The block is empty again after the run.
        chain_count  = 0;
        saw_bad_date = 1'b0;
        saw_overflow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest expectation.
    // Outputs are sampled at the edge, before the block's own updates land.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out want;
        t_out got;
        bit   wrong;
        if (i_rst_n && o_strobe) begin
            got = o_result;
            if (sorted_results.size() == 0) begin
                $error("result with nothing expected: day %0d month %0d year %0d plate %h",
                       got.out_day, got.out_month, got.out_year, got.out_plate);
                fail_count++;
            end else begin
                want  = sorted_results.pop_front();
                wrong = 1'b0;
                if (got.out_day !== want.out_day) begin
                    $error("out_day: expected %0d, got %0d", want.out_day, got.out_day);
                    wrong = 1'b1;
                end
                if (got.out_month !== want.out_month) begin
                    $error("out_month: expected %0d, got %0d", want.out_month, got.out_month);
                    wrong = 1'b1;
                end
                if (got.out_year !== want.out_year) begin
                    $error("out_year: expected %0d, got %0d", want.out_year, got.out_year);
                    wrong = 1'b1;
                end
                if (got.out_plate !== want.out_plate) begin
                    $error("out_plate: expected %h, got %h", want.out_plate, got.out_plate);
                    wrong = 1'b1;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    wrong = 1'b1;
                end
                if (got.last_result !== want.last_result) begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, got.last_result);
                    wrong = 1'b1;
                end
                if (wrong)
                    fail_count++;
                checked_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Record sender
    // ------------------------------------------------------------------
    // Set per phase: when high the sender streams back to back.
    bit no_gaps = 1'b0;

    // Draw a gap, then hold start and the item until the block takes it.
    // Start stays high on return so a following zero-gap item goes out
    // on the very next cycle.
    task automatic send_record(input t_in it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do
            @(posedge i_clk);
        while (busy);
        sort_record(it);
        sent_count++;
    endtask

    // Drop start and hold off until every expected result has come.
    task automatic wait_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sorted_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_in rec(input int day, input int month, input int year,
                                input logic [PLATE_W-1:0] plate, input bit last);
        t_in it;
        it.rec_day     = DAY_W'(day);
        it.rec_month   = MONTH_W'(month);
        it.rec_year    = YEAR_W'(year);
        it.plate       = plate;
        it.last_record = last;
        return it;
    endfunction

    // Random record. Valid ones often come from a narrow window of dates so
    // that equal and neighboring keys are common; invalid ones break one
    // field and leave the rest anywhere in their range.
    function automatic t_in make_random_record(input bit valid, input bit last);
        t_in it;
        it.plate       = {$urandom(), $urandom()};
        it.last_record = last;
        if (valid) begin
            if ($urandom_range(0, 2) == 0) begin
                it.rec_year  = YEAR_W'(2000 + $urandom_range(0, 1));
                it.rec_month = MONTH_W'($urandom_range(1, 2));
            end else begin
                it.rec_year  = YEAR_W'($urandom_range(0, 9999));
                it.rec_month = MONTH_W'($urandom_range(1, 12));
            end
            it.rec_day = DAY_W'($urandom_range(1, 31));
        end else begin
            it.rec_day   = DAY_W'($urandom_range(0, 31));
            it.rec_month = MONTH_W'($urandom_range(0, 15));
            it.rec_year  = YEAR_W'($urandom_range(0, 16383));
            case ($urandom_range(0, 2))
                0: begin
                    it.rec_day = '0;
                end
                1: begin
                    it.rec_month = ($urandom_range(0, 1) == 0) ? MONTH_W'(0)
                                                              : MONTH_W'($urandom_range(13, 15));
                end
                default: begin
                    it.rec_year = YEAR_W'($urandom_range(10000, 16383));
                end
            endcase
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and ties: the largest and smallest keys, a pair of
    // different dates with the same key, and two records with the same date.
    task automatic test_extremes_and_ties();
        send_record(rec(31, 12, 9999, {PLATE_W{1'b1}}, 1'b0));
        send_record(rec(1,  1,  0,    '0,              1'b0));
        send_record(rec(31, 1,  2020, "AB12CDE3",      1'b0));
        send_record(rec(1,  2,  2020, "ZX98YWV7",      1'b0));
        send_record(rec(15, 6,  2020, "FIRST001",      1'b0));
        send_record(rec(15, 6,  2020, "SECOND02",      1'b1));
    endtask

    // A set of one record.
    task automatic test_single_record();
        send_record(rec(29, 2, 1996, "LEAPDAY1", 1'b1));
    endtask

    // Out-of-range day, month and year, mid-set and as the last record.
    task automatic test_bad_dates();
        send_record(rec(10, 3, 1990, "GOOD0001", 1'b0));
        send_record(rec(0,  3, 1990, "BADDAY00", 1'b0));
        send_record(rec(11, 3, 1990, "GOOD0002", 1'b1));
        send_record(rec(5,  0, 2001, "MONTH000", 1'b1));
        send_record(rec(5,  13, 2001, "MONTH013", 1'b1));
        send_record(rec(7,  4, 2005, "GOOD0003", 1'b0));
        send_record(rec(5,  15, 2001, "MONTH015", 1'b1));
        send_record(rec(5,  7, 10000, "YEAR1000", 1'b1));
        send_record(rec(31, 15, 16383, {PLATE_W{1'b1}}, 1'b1));
        // The set after an error starts clean.
        send_record(rec(8,  8, 2008, "CLEAN008", 1'b1));
    endtask

    // Full chain, overflow, and overflow together with a bad date.
    task automatic test_capacity();
        no_gaps = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            send_record(make_random_record(1'b1, i == CAPACITY - 1));
        // Hold off until the full run has streamed out.
        wait_until_drained();

        no_gaps = 1'b1;
        for (int i = 0; i < CAPACITY + 3; i++)
            send_record(make_random_record(1'b1, i == CAPACITY + 2));

        no_gaps = 1'b0;
        send_record(make_random_record(1'b0, 1'b0));
        for (int i = 0; i < CAPACITY + 1; i++)
            send_record(make_random_record(1'b1, i == CAPACITY));
        // Overflowed set that ends on a bad date.
        for (int i = 0; i < CAPACITY + 1; i++)
            send_record(make_random_record(1'b1, 1'b0));
        send_record(make_random_record(1'b0, 1'b1));
    endtask

    // Random sets: mostly short and well formed, a few long enough to fill
    // or overflow the chain, some carrying bad dates.
    task automatic test_random_sets();
        int  set_len;
        int  pick;
        bit  noisy;
        while (sent_count < ITEM_TARGET) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            noisy   = ($urandom_range(0, 4) == 0);
            pick    = $urandom_range(0, 19);
            if (pick < 14)
                set_len = $urandom_range(1, 8);
            else if (pick < 19)
                set_len = $urandom_range(9, 24);
            else
                set_len = $urandom_range(CAPACITY - 2, CAPACITY + 4);
            for (int i = 0; i < set_len; i++)
                send_record(make_random_record(!noisy || $urandom_range(0, 3) != 0,
                                               i == set_len - 1));
            if ($urandom_range(0, 7) == 0)
                wait_until_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes_and_ties();
        test_single_record();
        test_bad_dates();
        test_capacity();
        test_random_sets();

        // Drain, then watch for stray results.
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d items in %0d sets: %0d bad-date, %0d overflow, largest %0d records",
                 sent_count, sets_done, bad_runs, overflow_runs, largest_run);
        $display("checked %0d results, %0d mismatching", checked_count, fail_count);
        if (fail_count == 0 && sorted_results.size() == 0)
            $display("tb_date_record_sorter: PASS");
        else
            $display("tb_date_record_sorter: FAIL");
        $finish;
    end

endmodule

### date_record_sorter.f
+incdir+hw/rtl
hw/rtl/drs_pkg.sv
hw/rtl/date_record_sorter.sv
hw/rtl/drs_checker.sv
tb/tb_date_record_sorter.sv
